// File: design/tccw_pkg.sv
// Shared types and constants for the text console character writer.
package tccw_pkg;

  // Field widths of the input and result items.
  localparam int CHAR_W      = 8;
  localparam int CELL_ADDR_W = 11;
  localparam int CELL_W      = 16;
  localparam int POS_W       = 11;
  localparam int COLOR_W     = 8;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

  // Command codes.
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Character and cell constants.
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;
  localparam logic [CELL_W-1:0]  CLEAR_CELL   = 16'h0F20;

  typedef struct packed {
    logic                   command;
    logic [CHAR_W-1:0]      character;
    logic [CELL_ADDR_W-1:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] read_data;
    logic [POS_W-1:0]  cursor_position;
    logic              scrolled;
  } out_item_t;

endpackage

// File: design/text_console_char_writer_core.sv
// Text console character writer: screen store, cursor, scroll sequencer and ports.
//
// Usage and operation: after reset the block sweeps the whole screen store to white-on-black
// blanks, one cell per cycle, and holds in_stall high meanwhile; text_color may be written
// over the APB port at any time the block is idle, including during that sweep. Once
// running, the block handles one item at a time. A put that does not scroll passes
// through the result state into the output register; a read first passes the read
// state, where the cell data is taken from the store. A put that runs the cursor off the
// last row (a wrap or a newline) scrolls the screen: the single read port and single
// write port of the screen store move one cell per cycle through a one-stage copy
// pipeline and then blank the bottom row. The store is read and written through one
// address counter pair shared by the clear, copy and blank phases, and the result waits
// in an output register until it is taken.
module text_console_char_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input item channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tccw_pkg::in_item_t                  in_data,
  // Result item channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output tccw_pkg::out_item_t                 out_data,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tccw_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [tccw_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CELL_COUNT    = ROWS * COLUMNS;
  localparam int ADDR_W        = $clog2(CELL_COUNT);
  localparam int CNT_W         = $clog2(CELL_COUNT + 1);
  localparam int ROW_W         = $clog2(ROWS);
  localparam int COL_W         = $clog2(COLUMNS);
  localparam int CMP_W         = (CNT_W > tccw_pkg::CELL_ADDR_W) ? CNT_W
                                                                 : tccw_pkg::CELL_ADDR_W;
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_RESULT
  } state_t;

  state_t                           state_r, state_nxt;
  logic [ROW_W-1:0]                 row_r, row_nxt;
  logic [COL_W-1:0]                 col_r, col_nxt;
  logic [ADDR_W-1:0]                pos_r, pos_nxt;
  logic [CNT_W-1:0]                 ptr_r, ptr_nxt;
  logic [CNT_W-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic                             cp_valid_r, cp_valid_nxt;
  logic [tccw_pkg::COLOR_W-1:0]     color_r, color_nxt;
  logic                             in_range_r, in_range_nxt;
  tccw_pkg::out_item_t              res_r, res_nxt;
  logic                             out_valid_r, out_valid_nxt;
  tccw_pkg::out_item_t              out_data_r, out_data_nxt;
  logic [tccw_pkg::CELL_W-1:0]      rd_data_r;

  logic [tccw_pkg::CELL_W-1:0]      screen [CELL_COUNT];

  logic                             accept_in;
  logic                             out_free;
  logic                             cfg_wr;
  logic                             is_newline;
  logic                             col_last;
  logic                             row_last;
  logic                             adv_row;
  logic                             need_scroll;
  logic                             reading;
  logic [ADDR_W-1:0]                put_pos;
  logic [ADDR_W-1:0]                nl_pos;
  logic [CMP_W-1:0]                 addr_ext;
  logic                             mem_we;
  logic [ADDR_W-1:0]                mem_wa;
  logic [tccw_pkg::CELL_W-1:0]      mem_wd;
  logic                             mem_re;
  logic [ADDR_W-1:0]                mem_ra;

  // Handshake decode.
  assign in_stall  = (state_r != S_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration port: always ready, one register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[tccw_pkg::CFG_ADDR_W-1:2] == tccw_pkg::REG_TEXT_COLOR)
                  ? tccw_pkg::CFG_DATA_W'(color_r) : '0;

  // Cursor advance for a put item.
  assign is_newline  = (in_data.character == tccw_pkg::NEWLINE_CHAR);
  assign col_last    = (col_r == COL_W'(COLUMNS - 1));
  assign row_last    = (row_r == ROW_W'(ROWS - 1));
  assign adv_row     = is_newline || col_last;
  assign need_scroll = adv_row && row_last;
  assign put_pos     = pos_r + ADDR_W'(1);
  assign nl_pos      = ADDR_W'((ADDR_W + 1)'(pos_r) - (ADDR_W + 1)'(col_r)
                               + (ADDR_W + 1)'(COLUMNS));

  // Read address range check.
  assign addr_ext = CMP_W'(in_data.cell_address);

  // The copy phase still has source cells to fetch.
  assign reading = (rd_ptr_r < CNT_W'(CELL_COUNT));

  // Screen store port selection for each phase.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_r[ADDR_W-1:0];
    mem_wd = tccw_pkg::CLEAR_CELL;
    mem_re = 1'b0;
    mem_ra = addr_ext[ADDR_W-1:0];
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_we = accept_in && (in_data.command == tccw_pkg::CMD_PUT) && !is_newline;
        mem_wa = pos_r;
        mem_wd = {color_r, in_data.character};
        mem_re = accept_in && (in_data.command == tccw_pkg::CMD_READ);
      end
      S_SCROLL: begin
        mem_we = cp_valid_r || !reading;
        mem_wd = cp_valid_r ? rd_data_r : {color_r, tccw_pkg::BLANK_CHAR};
        mem_re = reading;
        mem_ra = rd_ptr_r[ADDR_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Screen store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= screen[mem_ra];
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    pos_nxt       = pos_r;
    ptr_nxt       = ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    cp_valid_nxt  = 1'b0;
    color_nxt     = cfg_wr && (paddr[tccw_pkg::CFG_ADDR_W-1:2] == tccw_pkg::REG_TEXT_COLOR)
                    ? pwdata[tccw_pkg::COLOR_W-1:0] : color_r;
    in_range_nxt  = in_range_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      // Sweep the store to blanks after reset.
      S_CLEAR: begin
        ptr_nxt = ptr_r + CNT_W'(1);
        if (ptr_r == CNT_W'(CELL_COUNT - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      // Take an item; a put updates the cursor at once.
      S_IDLE: begin
        if (accept_in) begin
          res_nxt.read_data = '0;
          res_nxt.scrolled  = 1'b0;
          if (in_data.command == tccw_pkg::CMD_READ) begin
            in_range_nxt            = (addr_ext < CMP_W'(CELL_COUNT));
            res_nxt.cursor_position = tccw_pkg::POS_W'(pos_r);
            state_nxt               = S_READ;
          end else begin
            if (need_scroll) begin
              col_nxt = '0;
              pos_nxt = ADDR_W'(LAST_ROW_BASE);
            end else if (adv_row) begin
              col_nxt = '0;
              row_nxt = row_r + ROW_W'(1);
              pos_nxt = is_newline ? nl_pos : put_pos;
            end else begin
              col_nxt = col_r + COL_W'(1);
              pos_nxt = put_pos;
            end
            res_nxt.cursor_position = tccw_pkg::POS_W'(pos_nxt);
            res_nxt.scrolled        = need_scroll;
            if (need_scroll) begin
              ptr_nxt    = '0;
              rd_ptr_nxt = CNT_W'(COLUMNS);
              state_nxt  = S_SCROLL;
            end else begin
              state_nxt = S_RESULT;
            end
          end
        end
      end

      // Cell data arrives in the cycle after the read.
      S_READ: begin
        res_nxt.read_data = in_range_r ? rd_data_r : '0;
        state_nxt         = S_RESULT;
      end

      // Copy each row up one line, then blank the bottom row.
      S_SCROLL: begin
        cp_valid_nxt = reading;
        if (reading) begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        end
        if (mem_we) begin
          ptr_nxt = ptr_r + CNT_W'(1);
          if (ptr_r == CNT_W'(CELL_COUNT - 1)) begin
            state_nxt = S_RESULT;
          end
        end
      end

      // Hand the result to the output register once it is free.
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, cursor and registered outputs.
  always_ff @(posedge clk) begin
    in_range_r <= in_range_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      pos_r       <= '0;
      ptr_r       <= '0;
      rd_ptr_r    <= '0;
      cp_valid_r  <= 1'b0;
      color_r     <= tccw_pkg::RESET_COLOR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pos_r       <= pos_nxt;
      ptr_r       <= ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cp_valid_r  <= cp_valid_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The linear cursor always points inside the screen.
  assert property (@(posedge clk) disable iff (!rst_n) int'(pos_r) < CELL_COUNT)
    else $error("cursor position beyond the screen");

  // The linear cursor tracks row and column.
  assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == ADDR_W'(int'(row_r) * COLUMNS + int'(col_r)))
    else $error("linear cursor out of step with row and column");

  // Copied cells land above the bottom row only.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL && cp_valid_r) |-> (ptr_r < CNT_W'(LAST_ROW_BASE)))
    else $error("scroll copy wrote into the bottom row");

  // A scrolling put leaves the cursor at the start of the bottom row.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.scrolled) |->
      (out_data_r.cursor_position == tccw_pkg::POS_W'(LAST_ROW_BASE)))
    else $error("scrolled item reports a wrong cursor");

  // A new result is only loaded from the result state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_RESULT))
    else $error("result appeared outside the result state");

endmodule

// File: tb/tb_text_console_char_writer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text console character writer core.
module tb_text_console_char_writer_core;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ITEMS_PER_PHASE = 75;
  localparam logic [tccw_pkg::CFG_ADDR_W-1:0] COLOR_ADDR = {tccw_pkg::REG_TEXT_COLOR, 2'b00};

  // One line of the directed table: an item, how often to send it, and an
  // optional hand-written result.
  typedef struct packed {
    tccw_pkg::in_item_t  item;
    logic [7:0]          reps;
    logic                typed;
    tccw_pkg::out_item_t result;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  tccw_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  tccw_pkg::out_item_t             out_data;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [tccw_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [tccw_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [tccw_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  // Shadow copy of the console: screen contents, cursor and text color.
  logic [tccw_pkg::CELL_W-1:0]  screen_model [0:CELL_COUNT-1];
  int                           cur_row;
  int                           cur_col;
  logic [tccw_pkg::COLOR_W-1:0] color_now;

  tccw_pkg::out_item_t pending_results [$];
  int                  mismatches = 0;
  int                  accepted_items = 0;
  int                  send_idle_pct = 25;
  int                  recv_idle_pct = 86;

  text_console_char_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The result side stalls at random with the current idle rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t ns: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Applies one item to the shadow console and returns the result it gives.
  function automatic tccw_pkg::out_item_t next_console_result(tccw_pkg::in_item_t it);
    tccw_pkg::out_item_t r;
    r = '0;
    if (it.command == tccw_pkg::CMD_READ) begin
      if (it.cell_address < CELL_COUNT) begin
        r.read_data = screen_model[it.cell_address];
      end
    end else begin
      if (it.character == tccw_pkg::NEWLINE_CHAR) begin
        cur_row++;
        cur_col = 0;
      end else begin
        screen_model[cur_row * COLUMNS + cur_col] = {color_now, it.character};
        cur_col++;
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      // Running off the bottom moves every line up and blanks the last one.
      if (cur_row >= ROWS) begin
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
          screen_model[i] = screen_model[i + COLUMNS];
        end
        for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
          screen_model[i] = {color_now, tccw_pkg::BLANK_CHAR};
        end
        cur_row = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end
    r.cursor_position = tccw_pkg::POS_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  function automatic tccw_pkg::in_item_t make_item(logic cmd,
                                                   logic [tccw_pkg::CHAR_W-1:0] ch,
                                                   logic [tccw_pkg::CELL_ADDR_W-1:0] addr);
    tccw_pkg::in_item_t it;
    it.command = cmd;
    it.character = ch;
    it.cell_address = addr;
    return it;
  endfunction

  function automatic dir_row_t dir_row(logic cmd, logic [tccw_pkg::CHAR_W-1:0] ch,
                                       logic [tccw_pkg::CELL_ADDR_W-1:0] addr, int reps,
                                       logic typed, logic [tccw_pkg::CELL_W-1:0] rd,
                                       int pos, logic scr);
    dir_row_t r;
    r.item = make_item(cmd, ch, addr);
    r.reps = 8'(reps);
    r.typed = typed;
    r.result.read_data = rd;
    r.result.cursor_position = tccw_pkg::POS_W'(pos);
    r.result.scrolled = scr;
    return r;
  endfunction

  // Offers one item after a random gap and records its expected result once taken.
  task automatic send_item(input tccw_pkg::in_item_t item, input logic typed,
                           input tccw_pkg::out_item_t typed_result);
    tccw_pkg::out_item_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = next_console_result(item);
    pending_results.push_back(typed ? typed_result : predicted);
    accepted_items++;
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register transfer: a setup phase, then the access phase.
  task automatic apb_access(input logic wr, input logic [tccw_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [tccw_pkg::CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= COLOR_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_text_color(input logic [tccw_pkg::COLOR_W-1:0] value);
    logic [tccw_pkg::CFG_DATA_W-1:0] rd;
    apb_access(1'b1, tccw_pkg::CFG_DATA_W'(value), rd);
    color_now = value;
    apb_access(1'b0, '0, rd);
    if (rd !== tccw_pkg::CFG_DATA_W'(value))
      report_mismatch("text_color readback", rd, 32'(value));
  endtask

  // Every taken result is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    tccw_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_data), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", 32'(out_data.read_data), 32'(want.read_data));
        if (out_data.cursor_position !== want.cursor_position)
          report_mismatch("cursor_position", 32'(out_data.cursor_position),
                          32'(want.cursor_position));
        if (out_data.scrolled !== want.scrolled)
          report_mismatch("scrolled", 32'(out_data.scrolled), 32'(want.scrolled));
      end
    end
  end

  initial begin : stimulus
    dir_row_t                        dir_table [$];
    logic [tccw_pkg::CFG_DATA_W-1:0] rd;
    int                              phase_start;
    int                              kind;
    int                              len;
    int                              pos;
    int                              back;

    foreach (screen_model[i]) screen_model[i] = tccw_pkg::CLEAR_CELL;
    cur_row = 0;
    cur_col = 0;
    color_now = tccw_pkg::RESET_COLOR;

    // Directed items: blank screen reads, range edges, extreme bytes,
    // newline, a scroll caused by a newline, and ignored fields.
    dir_table.push_back(dir_row(tccw_pkg::CMD_READ, 8'h00, 11'd0, 1, 1'b1,
                                tccw_pkg::CLEAR_CELL, 0, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_READ, 8'h00, 11'd1999, 1, 1'b1,
                                tccw_pkg::CLEAR_CELL, 0, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_READ, 8'h00, 11'd2000, 1, 1'b1, 16'h0000, 0,
                                1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_READ, 8'h00, 11'd2047, 1, 1'b1, 16'h0000, 0,
                                1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_PUT, 8'h00, 11'd0, 1, 1'b1, 16'h0000, 1, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_PUT, 8'hFF, 11'd0, 1, 1'b1, 16'h0000, 2, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_READ, 8'h00, 11'd0, 1, 1'b1, 16'h0F00, 2,
                                1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_READ, 8'h00, 11'd1, 1, 1'b1, 16'h0FFF, 2,
                                1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_PUT, tccw_pkg::NEWLINE_CHAR, 11'd0, 1, 1'b1,
                                16'h0000, 80, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_PUT, 8'h7F, 11'd0, 1, 1'b0, '0, 0, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_PUT, 8'h80, 11'd0, 1, 1'b0, '0, 0, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_READ, 8'h00, 11'd80, 1, 1'b0, '0, 0, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_READ, 8'h00, 11'd2, 1, 1'b0, '0, 0, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_PUT, tccw_pkg::NEWLINE_CHAR, 11'd0, ROWS - 2,
                                1'b0, '0, 0, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_PUT, tccw_pkg::NEWLINE_CHAR, 11'd0, 1, 1'b1,
                                16'h0000, (ROWS - 1) * COLUMNS, 1'b1));
    dir_table.push_back(dir_row(tccw_pkg::CMD_READ, 8'h00, 11'd0, 1, 1'b0, '0, 0, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_READ, 8'h00, 11'd1999, 1, 1'b1,
                                tccw_pkg::CLEAR_CELL, (ROWS - 1) * COLUMNS, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_READ, 8'hFF, 11'd1920, 1, 1'b0, '0, 0, 1'b0));
    dir_table.push_back(dir_row(tccw_pkg::CMD_PUT, 8'h55, 11'd2047, 1, 1'b0, '0, 0, 1'b0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // The color register must come up at its reset value.
    apb_access(1'b0, '0, rd);
    if (rd !== tccw_pkg::CFG_DATA_W'(tccw_pkg::RESET_COLOR))
      report_mismatch("text_color after reset", rd, 32'(tccw_pkg::RESET_COLOR));

    foreach (dir_table[i]) begin
      repeat (dir_table[i].reps) begin
        send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].result);
      end
    end

    // Random traffic in three phases with different idle patterns and colors.
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 86;
          set_text_color(8'hFF);
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 25;
          set_text_color(8'h00);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          set_text_color(8'($urandom_range(1, 254)));
        end
      endcase
      phase_start = accepted_items;
      while (accepted_items < phase_start + ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          // A line of text; some are long enough to wrap.
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(75, 85) : $urandom_range(1, 30);
          repeat (len) begin
            send_item(make_item(tccw_pkg::CMD_PUT, 8'($urandom_range(0, 255)),
                                11'($urandom_range(0, 2047))), 1'b0, '0);
          end
          if ($urandom_range(0, 1) == 1) begin
            send_item(make_item(tccw_pkg::CMD_PUT, tccw_pkg::NEWLINE_CHAR,
                                11'($urandom_range(0, 2047))), 1'b0, '0);
          end
        end else if (kind < 55) begin
          repeat ($urandom_range(1, 6)) begin
            send_item(make_item(tccw_pkg::CMD_PUT, tccw_pkg::NEWLINE_CHAR,
                                11'($urandom_range(0, 2047))), 1'b0, '0);
          end
        end else if (kind < 80) begin
          // Reads, half of them just behind the cursor where text was written.
          repeat ($urandom_range(1, 6)) begin
            pos = cur_row * COLUMNS + cur_col;
            back = $urandom_range(0, (pos > 100) ? 100 : pos);
            send_item(make_item(tccw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                                ($urandom_range(0, 1) == 1) ? 11'(pos - back) :
                                                              11'($urandom_range(0, 2047))),
                      1'b0, '0);
          end
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_item(make_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                11'($urandom_range(0, 2047))), 1'b0, '0);
          end
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #80ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
